// ----- rtl/core/mcc_pkg.sv -----
// Shared constants, denomination lookup and the request/response types of the
// minimum-coin solver's table unit. No dependencies.
`default_nettype none

package mcc_pkg;

  localparam int MAX_AMOUNT = 1023;
  localparam int NUM_ROWS   = 7;
  localparam int MAX_RES    = 13;

  localparam int AMT_W     = 10;
  localparam int ENTRY_W   = 10;
  localparam int VAL_W     = 9;
  localparam int TOTAL_W   = 10;
  localparam int ROW_W     = 3;
  localparam int COL_W     = $clog2(MAX_AMOUNT + 1);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = NUM_ROWS * (2 ** COL_W);
  localparam int NRES_W    = $clog2(MAX_RES + 1);
  localparam int BUF_IDX_W = $clog2(MAX_RES);

  // Denomination of table row 1..7; row 0 has none.
  function automatic logic [VAL_W-1:0] denom(input logic [ROW_W-1:0] row);
    logic [VAL_W-1:0] d;
    begin
      case (row)
        3'd1:    d = 9'd1;
        3'd2:    d = 9'd5;
        3'd3:    d = 9'd10;
        3'd4:    d = 9'd20;
        3'd5:    d = 9'd50;
        3'd6:    d = 9'd100;
        3'd7:    d = 9'd500;
        default: d = 9'd0;
      endcase
      return d;
    end
  endfunction

  typedef struct packed {
    logic [ENTRY_W-1:0] a_val;      // fill: row below; walk: current row
    logic [ENTRY_W-1:0] b_val;      // fill: same row, col - coin; walk: row below
    logic               a_unreach;  // row below is the empty row during fill
    logic               b_use;      // coin fits in this column
    logic [COL_W-1:0]   col;        // walk column
    logic [ROW_W-1:0]   row;        // walk row
  } alu_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] fill_val;
    logic               differ;
    logic               take;
    logic [COL_W-1:0]   col_rem;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/mcc_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// Read during write to the same address returns the old contents.
`default_nettype none

module mcc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mcc_alu.sv -----
// Shared table unit: min-plus update for the fill, compare and column
// subtract for the walk back. Uses mcc_pkg.
`default_nettype none

module mcc_alu (
  input  mcc_pkg::alu_req_t req,
  output mcc_pkg::alu_rsp_t rsp
);
  import mcc_pkg::*;

  logic [ENTRY_W:0]   with_coin;
  logic [ENTRY_W:0]   without_coin;
  logic [ENTRY_W:0]   best;
  logic [COL_W-1:0]   coin;

  always_comb begin
    with_coin    = {1'b0, req.b_val} + {{ENTRY_W{1'b0}}, 1'b1};
    without_coin = req.a_unreach ? '1 : {1'b0, req.a_val};
    best         = (req.b_use && (with_coin < without_coin)) ? with_coin : without_coin;
    coin         = COL_W'(denom(req.row));

    rsp.fill_val = best[ENTRY_W-1:0];
    rsp.differ   = (req.a_val != req.b_val);
    rsp.take     = (req.col >= coin);
    rsp.col_rem  = req.col - coin;
  end

endmodule

`default_nettype wire

// ----- rtl/core/min_coin_change_solver_unit.sv -----
// Minimum-coin change solver, top level: sequencer, table RAM, shared table
// unit and output register. Uses mcc_pkg, mcc_ram and mcc_alu.
`default_nettype none

// An amount beat is taken only while the unit is idle. A nonzero amount A
// (saturated to MAX_AMOUNT) fills the 7-row coin table over the denominations
// 1, 5, 10, 20, 50, 100 and 500 at one table entry per cycle: the shared
// table unit does one min-plus update per cycle against the dual-read table
// RAM, with a one-deep write forward covering a read of the entry written in
// the same cycle. The last write of the fill overlaps the first walk read. The
// walk back then goes through a RAM read and a compare for each step, for at
// most 19 steps, recording up to 13 coins. Coins then go out one beat each,
// every beat carrying the total coin count; last_coin marks the final beat.
// The fill rate is set by the single write port of the table RAM. Receiver
// stalls add to the emit phase, during which in_ready stays low.
// A zero amount skips the table and gives a single beat with invalid_amount
// set, coin_value and coin_total zero. The table needs no clearing: every
// entry is written before it is read for the same amount. The next amount
// can be accepted while the final result beat still waits in the output
// register.
module min_coin_change_solver_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mcc_pkg::AMT_W-1:0]   amount_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [mcc_pkg::VAL_W-1:0]   coin_value,
  output logic      [mcc_pkg::TOTAL_W-1:0] coin_total,
  output logic                             invalid_amount,
  output logic                             last_coin
);
  import mcc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_FILL     = 5'b00010,
    ST_WALK_RD  = 5'b00100,
    ST_WALK_CMP = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  state_t             state;

  // Sequencer registers
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [COL_W-1:0]   amt;
  logic [NRES_W-1:0]  n;
  logic [NRES_W-1:0]  k;
  logic               first;
  logic               inval;
  logic [TOTAL_W-1:0] total;
  logic [ROW_W-1:0]   cbuf [MAX_RES];

  // Fill pipeline stage (entry being written)
  logic               s_vld;
  logic [ROW_W-1:0]   s_row;
  logic [COL_W-1:0]   s_col;
  logic               s_b_use;
  logic               s_row1;

  // Write forward
  logic               fwd_a;
  logic               fwd_b;
  logic [ENTRY_W-1:0] fwd_data;

  // RAM ports
  logic [ADDR_W-1:0]  ra;
  logic [ADDR_W-1:0]  rb;
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;

  logic [COL_W-1:0]   coin_col;
  logic               iss_b_use;
  logic [COL_W-1:0]   iss_b_col;
  logic [ENTRY_W-1:0] a_sel;
  logic [ENTRY_W-1:0] b_sel;
  alu_req_t           req;
  alu_rsp_t           rsp;

  logic [COL_W-1:0]   amt_sat;
  logic               out_load;
  logic               emit_last;
  logic [NRES_W-1:0]  n_inc;
  logic [ROW_W-1:0]   emit_row;

  assign in_ready = (state == ST_IDLE);

  // Issue side of the fill: this cycle's entry is (row, col).
  always_comb begin
    coin_col  = COL_W'(denom(row));
    iss_b_use = (col != '0) && (col >= coin_col);
    iss_b_col = col - coin_col;
  end

  always_comb begin
    ra = '0;
    rb = '0;
    unique case (state)
      ST_FILL: begin
        ra = {row - ROW_W'(2), col};
        rb = {row - ROW_W'(1), iss_b_col};
      end
      ST_WALK_RD: begin
        ra = {row - ROW_W'(1), col};
        rb = {row - ROW_W'(2), col};
      end
      default: begin
        ra = '0;
        rb = '0;
      end
    endcase
  end

  assign a_sel = fwd_a ? fwd_data : rd_a;
  assign b_sel = fwd_b ? fwd_data : rd_b;

  // Column 0 is always zero coins; row 1 has the empty row below it,
  // unreachable in the fill and zero in the walk.
  always_comb begin
    req.a_val     = (s_vld && (s_col == '0)) ? '0 : a_sel;
    req.b_val     = (!s_vld && s_row1) ? '0 : b_sel;
    req.a_unreach = s_vld && s_row1 && (s_col != '0);
    req.b_use     = s_vld && s_b_use;
    req.col       = col;
    req.row       = row;
  end

  mcc_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  assign we    = s_vld;
  assign waddr = {s_row - ROW_W'(1), s_col};
  assign wdata = rsp.fill_val;

  mcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    if (32'(amount_in) > MAX_AMOUNT) begin
      amt_sat = COL_W'(MAX_AMOUNT);
    end else begin
      amt_sat = COL_W'(amount_in);
    end
    out_load  = (state == ST_EMIT) && (!out_valid || out_ready);
    emit_last = (k == (n - NRES_W'(1)));
    n_inc     = n + NRES_W'(1);
    emit_row  = cbuf[k[BUF_IDX_W-1:0]];
  end

  // Pipeline stage and write forward: run every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= (state == ST_FILL);
    end
    s_row    <= row;
    s_col    <= col;
    s_b_use  <= iss_b_use;
    s_row1   <= (row == ROW_W'(1));
    fwd_a    <= we && (waddr == ra);
    fwd_b    <= we && (waddr == rb);
    fwd_data <= wdata;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            k     <= '0;
            first <= 1'b1;
            if (amount_in == '0) begin
              inval <= 1'b1;
              total <= '0;
              n     <= NRES_W'(1);
              state <= ST_EMIT;
            end else begin
              inval <= 1'b0;
              n     <= '0;
              amt   <= amt_sat;
              row   <= ROW_W'(1);
              col   <= '0;
              state <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (col == amt) begin
            if (row == ROW_W'(NUM_ROWS)) begin
              state <= ST_WALK_RD;
            end else begin
              col <= '0;
              row <= row + ROW_W'(1);
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        ST_WALK_RD: begin
          state <= ST_WALK_CMP;
        end
        ST_WALK_CMP: begin
          first <= 1'b0;
          if (first) begin
            total <= TOTAL_W'(req.a_val);
          end
          if (rsp.differ) begin
            if (rsp.take) begin
              cbuf[n[BUF_IDX_W-1:0]] <= row;
              n     <= n_inc;
              col   <= rsp.col_rem;
              state <= (n_inc == NRES_W'(MAX_RES)) ? ST_EMIT : ST_WALK_RD;
            end else begin
              // Entry differs but the coin does not fit: stop here.
              state <= (n == '0) ? ST_IDLE : ST_EMIT;
            end
          end else if (row == ROW_W'(1)) begin
            state <= (n == '0) ? ST_IDLE : ST_EMIT;
          end else begin
            row   <= row - ROW_W'(1);
            state <= ST_WALK_RD;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            k <= k + NRES_W'(1);
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      coin_value     <= inval ? '0 : denom(emit_row);
      coin_total     <= total;
      invalid_amount <= inval;
      last_coin      <= emit_last;
    end
  end

endmodule

`default_nettype wire
